@@ rtl/core/dalm_pkg.sv @@
package dalm_pkg;

    localparam int THREADS = 16;
    localparam int LOCKS   = 16;

    localparam int TID_W     = 4;
    localparam int LID_W     = 4;
    localparam int THREAD_AW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int LOCK_AW   = (LOCKS > 1) ? $clog2(LOCKS) : 1;
    localparam int STEP_W    = $clog2(THREADS + 1);

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [1:0] ST_GRANTED  = 2'd0;
    localparam logic [1:0] ST_WAIT     = 2'd1;
    localparam logic [1:0] ST_DEADLOCK = 2'd2;
    localparam logic [1:0] ST_RELEASED = 2'd3;

    typedef struct packed {
        logic             command;
        logic [TID_W-1:0] thread_id;
        logic [LID_W-1:0] lock_id;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             holder_valid;
        logic [TID_W-1:0] holder_thread;
    } rsp_t;

    // Write controls for the owner and pending tables.
    typedef struct packed {
        logic                 own_we;
        logic                 own_set;
        logic [LOCK_AW-1:0]   own_lock;
        logic [TID_W-1:0]     own_thread;
        logic                 pend_we;
        logic                 pend_set;
        logic [THREAD_AW-1:0] pend_thread;
        logic [LOCK_AW-1:0]   pend_lock;
    } tbl_wr_t;

endpackage

@@ rtl/core/dalm_tables.sv @@
module dalm_tables
    import dalm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [LOCK_AW-1:0]   lock_raddr,
    input  logic [THREAD_AW-1:0] thread_raddr,
    input  tbl_wr_t              wr,
    output logic                 owner_valid,
    output logic [TID_W-1:0]     owner_thread,
    output logic                 pend_valid,
    output logic [LOCK_AW-1:0]   pend_lock
);

    logic [LOCKS-1:0]     owner_valid_reg;
    logic [TID_W-1:0]     owner_thread_reg [LOCKS];
    logic [THREADS-1:0]   pend_valid_reg;
    logic [LOCK_AW-1:0]   pend_lock_reg [THREADS];

    // Valid bits are the only state that reset has to clear.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_valid_reg <= '0;
            pend_valid_reg  <= '0;
        end else begin
            if (wr.own_we) begin
                owner_valid_reg[wr.own_lock] <= wr.own_set;
            end
            if (wr.pend_we) begin
                pend_valid_reg[wr.pend_thread] <= wr.pend_set;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.own_we) begin
            owner_thread_reg[wr.own_lock] <= wr.own_thread;
        end
        if (wr.pend_we) begin
            pend_lock_reg[wr.pend_thread] <= wr.pend_lock;
        end
    end

    assign owner_valid  = owner_valid_reg[lock_raddr];
    assign owner_thread = owner_thread_reg[lock_raddr];
    assign pend_valid   = pend_valid_reg[thread_raddr];
    assign pend_lock    = pend_lock_reg[thread_raddr];

endmodule

@@ rtl/core/deadlock_avoiding_lock_manager.sv @@
// Lock manager with deadlock detection over the wait-for graph.
// A request on the s_ channel (s_valid, s_ready, s_data) either acquires a
// lock for a thread or releases a lock. Each request yields exactly one
// response on the m_ channel (m_valid, m_ready, m_data): granted, must wait,
// rejected as a deadlock, or released, plus the lock's owner afterwards.
// An acquire of a lock held by another thread walks the chain owner, that
// owner's pending lock, that lock's owner, and so on, one link per clock
// cycle through the single read port of the owner and pending tables, for
// at most THREADS links. Only one request is in progress at a time: s_ready
// is high only while the block is idle, and it stays low until the response
// has been taken. When the receiver holds m_ready low, m_data is held and no
// new request is accepted. Reset (aresetn low, synchronous) frees every lock
// and clears every pending request; the block is ready right after it.
module deadlock_avoiding_lock_manager
    import dalm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_RESP
    } state_t;

    state_t              state_reg;
    req_t                req_reg;
    logic [TID_W-1:0]    cur_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [TID_W-1:0]    holder_reg;
    logic                m_valid_reg;
    rsp_t                rsp_reg;

    logic [LOCK_AW-1:0]  lock_raddr;
    logic                owner_valid;
    logic [TID_W-1:0]    owner_thread;
    logic                pend_valid;
    logic [LOCK_AW-1:0]  pend_lock;
    tbl_wr_t             wr;

    logic                in_range;
    logic                walk_done;
    logic [1:0]          walk_status;

    // While walking, the lock port follows the current thread's pending lock;
    // otherwise it looks at the requested lock.
    assign lock_raddr = (state_reg == S_WALK) ? pend_lock : LOCK_AW'(req_reg.lock_id);

    dalm_tables u_tables (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .lock_raddr   (lock_raddr),
        .thread_raddr (THREAD_AW'(cur_reg)),
        .wr           (wr),
        .owner_valid  (owner_valid),
        .owner_thread (owner_thread),
        .pend_valid   (pend_valid),
        .pend_lock    (pend_lock)
    );

    assign in_range = (32'(req_reg.thread_id) < THREADS) && (32'(req_reg.lock_id) < LOCKS);

    // One link of the chain. The walk ends when the step budget is spent, the
    // chain comes back to the requester, or it reaches a thread that is not
    // waiting or a lock that is free.
    always_comb begin
        walk_done   = 1'b1;
        walk_status = ST_WAIT;
        if (step_reg == STEP_W'(THREADS)) begin
            walk_status = ST_WAIT;
        end else if (cur_reg == req_reg.thread_id) begin
            walk_status = ST_DEADLOCK;
        end else if (!pend_valid || !owner_valid) begin
            walk_status = ST_WAIT;
        end else begin
            walk_done = 1'b0;
        end
    end

    // Table updates happen in the cycle in which the outcome is decided.
    always_comb begin
        wr             = '0;
        wr.own_lock    = LOCK_AW'(req_reg.lock_id);
        wr.own_thread  = req_reg.thread_id;
        wr.pend_thread = THREAD_AW'(req_reg.thread_id);
        wr.pend_lock   = LOCK_AW'(req_reg.lock_id);
        case (state_reg)
            S_CHECK: begin
                if (in_range) begin
                    if (req_reg.command == CMD_RELEASE) begin
                        wr.own_we  = 1'b1;
                        wr.own_set = 1'b0;
                    end else if (!owner_valid) begin
                        wr.own_we   = 1'b1;
                        wr.own_set  = 1'b1;
                        wr.pend_we  = 1'b1;
                        wr.pend_set = 1'b0;
                    end else if (owner_thread == req_reg.thread_id) begin
                        wr.pend_we  = 1'b1;
                        wr.pend_set = 1'b0;
                    end
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    wr.pend_we  = 1'b1;
                    wr.pend_set = (walk_status == ST_WAIT);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg   <= s_data;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!in_range) begin
                        rsp_reg   <= '{ST_DEADLOCK, 1'b0, '0};
                        state_reg <= S_RESP;
                    end else if (req_reg.command == CMD_RELEASE) begin
                        rsp_reg   <= '{ST_RELEASED, 1'b0, '0};
                        state_reg <= S_RESP;
                    end else if (!owner_valid) begin
                        rsp_reg   <= '{ST_GRANTED, 1'b1, req_reg.thread_id};
                        state_reg <= S_RESP;
                    end else if (owner_thread == req_reg.thread_id) begin
                        rsp_reg   <= '{ST_DEADLOCK, 1'b1, owner_thread};
                        state_reg <= S_RESP;
                    end else begin
                        // The lock is held by another thread: start the walk.
                        holder_reg <= owner_thread;
                        cur_reg    <= owner_thread;
                        step_reg   <= '0;
                        state_reg  <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (walk_done) begin
                        rsp_reg   <= '{walk_status, 1'b1, holder_reg};
                        state_reg <= S_RESP;
                    end else begin
                        cur_reg  <= owner_thread;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_RESP: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                    end else if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

// Testbench for the deadlock avoiding lock manager.
//
// Every request sent to the block is mirrored into a local model of the lock
// tables. At the moment the block accepts a request, the model works out the
// response the block must give and queues it. Responses are checked in order
// against that queue. The block handles one request at a time, so the queue
// never holds more than one entry under correct operation.
module tb_top
    import dalm_pkg::*;
();

    // A long receiver hold-off (LONG_HOLD) can leave both channels quiet, so the
    // watchdog limit sits well above that hold-off.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 1500;
    localparam int DRAIN_CYCLES   = 3 * (THREADS + 3);
    localparam int LONG_HOLD      = 400;
    localparam int MAX_PRINTED    = 100;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    req_t s_data;
    logic m_valid;
    logic m_ready;
    rsp_t m_data;

    deadlock_avoiding_lock_manager dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // Local copy of the owner and pending tables, as they stand after reset.
    logic [TID_W-1:0] holder_of   [LOCKS];
    logic             lock_held   [LOCKS];
    logic [LID_W-1:0] wanted_lock [THREADS];
    logic             is_waiting  [THREADS];

    rsp_t expected_q[$];
    int   errors        = 0;
    int   resp_count    = 0;
    int   items_sent    = 0;
    int   stall_cycles  = 0;

    // Sender state. The fixed flag marks a directed request whose response
    // is written out in the table instead of taken from the model.
    logic drv_fixed;
    rsp_t drv_want;
    int   burst_left = 0;

    // One row of the directed table. The expected fields are only meaningful
    // when the fixed bit is set.
    typedef struct packed {
        logic             cmd;
        logic [TID_W-1:0] thr;
        logic [LID_W-1:0] lck;
        logic             fixed;
        logic [1:0]       st;
        logic             hv;
        logic [TID_W-1:0] ht;
    } stim_row_t;

    localparam int DIR_ROWS = 23;

    stim_row_t dir_table [DIR_ROWS] = '{
        // Fresh tables: the extreme threads take the extreme locks.
        '{CMD_ACQUIRE, 4'd0,  4'd0,  1'b1, ST_GRANTED,  1'b1, 4'd0},
        '{CMD_ACQUIRE, 4'd15, 4'd15, 1'b1, ST_GRANTED,  1'b1, 4'd15},
        // A thread asking again for a lock it already holds is rejected.
        '{CMD_ACQUIRE, 4'd0,  4'd0,  1'b1, ST_DEADLOCK, 1'b1, 4'd0},
        // Releasing a free lock changes nothing.
        '{CMD_RELEASE, 4'd3,  4'd9,  1'b1, ST_RELEASED, 1'b0, 4'd0},
        // Two threads each holding a lock and wanting the other's.
        '{CMD_ACQUIRE, 4'd1,  4'd1,  1'b0, ST_GRANTED,  1'b0, 4'd0},
        '{CMD_ACQUIRE, 4'd1,  4'd0,  1'b0, ST_GRANTED,  1'b0, 4'd0},
        '{CMD_ACQUIRE, 4'd0,  4'd1,  1'b0, ST_GRANTED,  1'b0, 4'd0},
        // Waiting again on another lock replaces the earlier pending request,
        // which then closes a different cycle.
        '{CMD_ACQUIRE, 4'd1,  4'd15, 1'b0, ST_GRANTED,  1'b0, 4'd0},
        '{CMD_ACQUIRE, 4'd15, 4'd1,  1'b0, ST_GRANTED,  1'b0, 4'd0},
        // A release by a thread that does not own the lock still frees it.
        '{CMD_RELEASE, 4'd7,  4'd15, 1'b1, ST_RELEASED, 1'b0, 4'd0},
        '{CMD_ACQUIRE, 4'd1,  4'd15, 1'b0, ST_GRANTED,  1'b0, 4'd0},
        // Chains that stop at a thread with nothing pending.
        '{CMD_ACQUIRE, 4'd0,  4'd15, 1'b0, ST_GRANTED,  1'b0, 4'd0},
        '{CMD_ACQUIRE, 4'd3,  4'd0,  1'b0, ST_GRANTED,  1'b0, 4'd0},
        // A chain that runs into a lock freed behind it.
        '{CMD_RELEASE, 4'd5,  4'd15, 1'b1, ST_RELEASED, 1'b0, 4'd0},
        '{CMD_ACQUIRE, 4'd4,  4'd0,  1'b0, ST_GRANTED,  1'b0, 4'd0},
        '{CMD_ACQUIRE, 4'd0,  4'd15, 1'b0, ST_GRANTED,  1'b0, 4'd0},
        '{CMD_ACQUIRE, 4'd4,  4'd15, 1'b0, ST_GRANTED,  1'b0, 4'd0},
        '{CMD_ACQUIRE, 4'd0,  4'd0,  1'b1, ST_DEADLOCK, 1'b1, 4'd0},
        // Free everything that is held, then reuse a freed lock.
        '{CMD_RELEASE, 4'd15, 4'd15, 1'b1, ST_RELEASED, 1'b0, 4'd0},
        '{CMD_RELEASE, 4'd0,  4'd0,  1'b1, ST_RELEASED, 1'b0, 4'd0},
        '{CMD_RELEASE, 4'd1,  4'd1,  1'b1, ST_RELEASED, 1'b0, 4'd0},
        '{CMD_ACQUIRE, 4'd15, 4'd0,  1'b1, ST_GRANTED,  1'b1, 4'd15},
        '{CMD_RELEASE, 4'd15, 4'd0,  1'b1, ST_RELEASED, 1'b0, 4'd0}
    };

    initial begin
        for (int i = 0; i < LOCKS; i++) begin
            holder_of[i] = '0;
            lock_held[i] = 1'b0;
        end
        for (int i = 0; i < THREADS; i++) begin
            wanted_lock[i] = '0;
            is_waiting[i]  = 1'b0;
        end
    end

    // Follows the wait-for chain starting at the owner of lock lk. Returns 1
    // when the chain reaches thread th within THREADS links.
    function automatic bit walk_closes_cycle(int unsigned th, int unsigned lk);
        int unsigned cur;
        int unsigned nl;
        cur = 32'(holder_of[lk]);
        for (int step = 0; step < THREADS; step++) begin
            if (cur >= THREADS) return 1'b0;
            if (cur == th) return 1'b1;
            if (!is_waiting[cur]) return 1'b0;
            nl = 32'(wanted_lock[cur]);
            if (nl >= LOCKS || !lock_held[nl]) return 1'b0;
            cur = 32'(holder_of[nl]);
        end
        return 1'b0;
    endfunction

    // Applies one request to the local tables and returns the response the
    // block has to produce for it.
    function automatic rsp_t apply_lock_op(req_t r);
        rsp_t        o;
        int unsigned th;
        int unsigned lk;
        o  = '0;
        th = 32'(r.thread_id);
        lk = 32'(r.lock_id);
        if (th >= THREADS || lk >= LOCKS) begin
            o.status = ST_DEADLOCK;
            return o;
        end
        if (r.command == CMD_RELEASE) begin
            lock_held[lk] = 1'b0;
            holder_of[lk] = '0;
            o.status = ST_RELEASED;
        end else if (!lock_held[lk]) begin
            lock_held[lk]   = 1'b1;
            holder_of[lk]   = r.thread_id;
            is_waiting[th]  = 1'b0;
            wanted_lock[th] = '0;
            o.status = ST_GRANTED;
        end else if (holder_of[lk] == r.thread_id || walk_closes_cycle(th, lk)) begin
            is_waiting[th]  = 1'b0;
            wanted_lock[th] = '0;
            o.status = ST_DEADLOCK;
        end else begin
            is_waiting[th]  = 1'b1;
            wanted_lock[th] = r.lock_id;
            o.status = ST_WAIT;
        end
        o.holder_valid  = lock_held[lk];
        o.holder_thread = lock_held[lk] ? holder_of[lk] : '0;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("%0t MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Offers one request and returns once the block has taken it. The sender
    // works in bursts: between bursts it drops valid for a random gap. Once
    // valid is up it stays up with the same payload until accepted.
    task automatic send_request(input logic cmd, input logic [TID_W-1:0] thr,
                                input logic [LID_W-1:0] lck, input logic fixed,
                                input rsp_t want);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
            // Now and then a very long burst gives a stretch with no sender gaps.
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid           <= 1'b1;
        s_data.command    <= cmd;
        s_data.thread_id  <= thr;
        s_data.lock_id    <= lck;
        drv_fixed = fixed;
        drv_want  = want;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Scoreboard. Responses are matched first, so a response and a new
    // request on the same edge never see a half-updated queue.
    always @(posedge aclk) begin : scoreboard
        rsp_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                resp_count++;
                if (expected_q.size() == 0) begin
                    report_mismatch("response with no request outstanding",
                                    32'(m_data.status), 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", 32'(m_data.status), 32'(want.status));
                    if (m_data.holder_valid !== want.holder_valid)
                        report_mismatch("holder_valid", 32'(m_data.holder_valid),
                                        32'(want.holder_valid));
                    if (m_data.holder_thread !== want.holder_thread)
                        report_mismatch("holder_thread", 32'(m_data.holder_thread),
                                        32'(want.holder_thread));
                end
            end
            if (s_valid && s_ready) begin
                // The model always advances; a directed row only overrides
                // what is expected on the wire.
                want = apply_lock_op(s_data);
                if (drv_fixed) want = drv_want;
                expected_q.push_back(want);
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver. It switches between stall patterns of random length: always
    // ready, coin flip, mostly stalled and mostly ready. Once, after a couple
    // hundred responses, it holds off for a long stretch while the sender
    // keeps offering, so the block sits on a response and s_ready stays low.
    initial begin : receiver
        int  mode;
        int  len;
        bit  long_done;
        long_done = 1'b0;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!long_done && resp_count >= 200) begin
                long_done = 1'b1;
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(10, 80);
                repeat (len) begin
                    @(negedge aclk);
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= 1'($urandom_range(0, 1));
                        2: m_ready <= ($urandom_range(0, 3) == 0);
                        default: m_ready <= ($urandom_range(0, 5) != 0);
                    endcase
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int               thr_perm [16];
        int               lck_perm [16];
        int               n;
        int               j;
        int               tmp;
        int               pick;
        logic             cmd;
        logic [LID_W-1:0] lck;
        rsp_t             want;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        drv_fixed = 1'b0;
        drv_want  = '0;
        for (int i = 0; i < 16; i++) begin
            thr_perm[i] = i;
            lck_perm[i] = i;
        end

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        for (int i = 0; i < DIR_ROWS; i++) begin
            want.status        = dir_table[i].st;
            want.holder_valid  = dir_table[i].hv;
            want.holder_thread = dir_table[i].ht;
            send_request(dir_table[i].cmd, dir_table[i].thr, dir_table[i].lck,
                         dir_table[i].fixed, want);
        end

        // Random part. Most of it builds wait-for chains of distinct threads
        // and locks and then closes, breaks or retries them; the rest is
        // loose traffic concentrated on a few locks to cause contention.
        while (items_sent < TARGET_ITEMS) begin
            if ($urandom_range(0, 9) < 6) begin
                for (int i = 15; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = thr_perm[i]; thr_perm[i] = thr_perm[j]; thr_perm[j] = tmp;
                    j = $urandom_range(0, i);
                    tmp = lck_perm[i]; lck_perm[i] = lck_perm[j]; lck_perm[j] = tmp;
                end
                // Most chains are short; now and then one spans every thread,
                // which is the longest walk the block can make.
                n = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(2, 6);

                // Free the chain's locks, hand one to each thread, then let
                // every thread after the first wait on its predecessor's lock.
                for (int i = 0; i < n; i++)
                    send_request(CMD_RELEASE, TID_W'($urandom_range(0, 15)),
                                 LID_W'(lck_perm[i]), 1'b0, '0);
                for (int i = 0; i < n; i++)
                    send_request(CMD_ACQUIRE, TID_W'(thr_perm[i]), LID_W'(lck_perm[i]),
                                 1'b0, '0);
                for (int i = 1; i < n; i++)
                    send_request(CMD_ACQUIRE, TID_W'(thr_perm[i]), LID_W'(lck_perm[i-1]),
                                 1'b0, '0);

                pick = $urandom_range(0, 5);
                if (pick <= 2) begin
                    // The head of the chain asks for the tail's lock.
                    send_request(CMD_ACQUIRE, TID_W'(thr_perm[0]), LID_W'(lck_perm[n-1]),
                                 1'b0, '0);
                end else if (pick == 3) begin
                    send_request(CMD_ACQUIRE, TID_W'($urandom_range(0, 15)),
                                 LID_W'(lck_perm[n-1]), 1'b0, '0);
                end else if (pick == 4) begin
                    // Break a link somewhere first, then try to close.
                    send_request(CMD_RELEASE, TID_W'($urandom_range(0, 15)),
                                 LID_W'(lck_perm[$urandom_range(0, n-1)]), 1'b0, '0);
                    send_request(CMD_ACQUIRE, TID_W'(thr_perm[0]), LID_W'(lck_perm[n-1]),
                                 1'b0, '0);
                end else begin
                    // A waiter retries after the lock it wants is released.
                    send_request(CMD_RELEASE, TID_W'(thr_perm[0]), LID_W'(lck_perm[0]),
                                 1'b0, '0);
                    send_request(CMD_ACQUIRE, TID_W'(thr_perm[1]), LID_W'(lck_perm[0]),
                                 1'b0, '0);
                end
            end else begin
                repeat ($urandom_range(1, 20)) begin
                    cmd = ($urandom_range(0, 3) == 0) ? CMD_RELEASE : CMD_ACQUIRE;
                    lck = ($urandom_range(0, 1) == 0) ? LID_W'($urandom_range(0, 3))
                                                      : LID_W'($urandom_range(0, 15));
                    send_request(cmd, TID_W'($urandom_range(0, 15)), lck, 1'b0, '0);
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // Wait for the last responses, then give the block time to show any
        // response it should not produce.
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ deadlock_avoiding_lock_manager.f @@
rtl/core/dalm_pkg.sv
rtl/core/dalm_tables.sv
rtl/core/deadlock_avoiding_lock_manager.sv
bench/tb_top.sv
